[hw/rtl/lse_pkg.sv]
// Shared constants, codes and structs of the Legendre series evaluator.
// Used by the top level, the divider and the engine; depends on nothing.
package lse_pkg;

   localparam int MAX_TERMS = 1024;
   localparam int COEF_ADDR_W = $clog2(MAX_TERMS);
   localparam int TERM_CNT_W = $clog2(MAX_TERMS + 1);

   localparam int COEF_W = 32;
   localparam int Q_W = 32;
   localparam int Q_FRAC = 30;
   localparam int PW_W = 31;
   localparam int FR_SHIFT = 18;
   localparam int SUM_W = 48;
   localparam int SUMX_W = SUM_W + 1;
   localparam int ONE_Q30 = 1 << Q_FRAC;

   localparam int MUL_W = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int FR_FULL_W = 64 - FR_SHIFT;

   localparam int NUM_W = TERM_CNT_W + 33;
   localparam int DIV_BITS = 4;
   localparam int DIV_ITER = (NUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int QUO_W = DIV_ITER * DIV_BITS;
   localparam int ITER_W = $clog2(DIV_ITER + 1);

   localparam int CSR_IDX_W = 2;
   localparam int TERM_COUNT_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT = 2'd1;
   localparam logic [31:0] INV_RADIUS_RESET = 32'd8589935;
   localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 11'd1000;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic [31:0]           radial_pos;
      logic signed [Q_W-1:0] eta;
   } eval_cmd_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic [TERM_CNT_W-1:0]   den;
   } div_in_type;

   typedef struct packed {
      logic                  done;
      logic signed [Q_W-1:0] quot;
   } div_out_type;

endpackage

[hw/rtl/legendre_series_eval_top.sv]
// Top level of the Legendre series evaluator: configuration registers,
// request decode, coefficient RAM, divider and evaluation sequencer.
// Depends on lse_pkg, lse_ram, lse_div and lse_engine.
//
//  Channel | Direction | Handshake             | Payload
//  req_    | in        | start & !busy         | type, coef index/value, position, cosine
//  rsp_    | out       | rsp_valid, one cycle  | series sum, saturated flag
//  csr_    | in        | csr_valid & csr_ready | register index, write data
//
// A load transaction does not raise busy, and a new one is taken on the next clock.
// An evaluate transaction is paced by the divider wait of each recurrence step
// and by the shared multiplier; with no terms it goes straight to the result.
// Reset returns the sequencer to idle and sets the configuration registers to their
// reset values; the coefficient table is not cleared and an entry holds no defined value until it is loaded.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module legendre_series_eval_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_type,
   input  logic [9:0]                           req_coef_index,
   input  logic signed [lse_pkg::COEF_W-1:0]    req_coef_value,
   input  logic [31:0]                          req_radial_pos,
   input  logic signed [lse_pkg::Q_W-1:0]       req_direction_cosine,
   output logic                                 rsp_valid,
   output logic signed [lse_pkg::SUM_W-1:0]     rsp_series_sum,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lse_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                          csr_wdata
);

   logic [31:0]                          inv_radius_ff, inv_radius_in;
   logic [lse_pkg::TERM_COUNT_W-1:0]     term_count_ff, term_count_in;
   logic                                 accept;
   logic                                 ram_we;
   logic [lse_pkg::COEF_ADDR_W-1:0]      ram_addr;
   logic [lse_pkg::COEF_ADDR_W-1:0]      rd_addr;
   logic [lse_pkg::COEF_W-1:0]           rd_data;
   logic signed [lse_pkg::Q_W-1:0]       eta_clip;
   lse_pkg::eval_cmd_type                cmd;
   lse_pkg::div_in_type                  div_in;
   lse_pkg::div_out_type                 div_out;

   assign csr_ready = !busy;
   assign accept    = start && !busy;

   always_comb begin
      inv_radius_in = inv_radius_ff;
      term_count_in = term_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lse_pkg::CSR_INV_RADIUS: inv_radius_in = csr_wdata;
            lse_pkg::CSR_TERM_COUNT: term_count_in = csr_wdata[lse_pkg::TERM_COUNT_W-1:0];
            default: begin
               inv_radius_in = inv_radius_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_radius_ff <= lse_pkg::INV_RADIUS_RESET;
         term_count_ff <= lse_pkg::TERM_COUNT_RESET;
      end else begin
         inv_radius_ff <= inv_radius_in;
         term_count_ff <= term_count_in;
      end
   end

   always_comb begin
      if (req_direction_cosine > lse_pkg::Q_W'(lse_pkg::ONE_Q30)) begin
         eta_clip = lse_pkg::Q_W'(lse_pkg::ONE_Q30);
      end else if (req_direction_cosine < lse_pkg::Q_W'(-lse_pkg::ONE_Q30)) begin
         eta_clip = lse_pkg::Q_W'(-lse_pkg::ONE_Q30);
      end else begin
         eta_clip = req_direction_cosine;
      end
   end

   assign cmd.valid      = accept && (req_type == lse_pkg::REQ_EVAL);
   assign cmd.radial_pos = req_radial_pos;
   assign cmd.eta        = eta_clip;

   assign ram_we   = accept && (req_type == lse_pkg::REQ_LOAD)
                     && (32'(req_coef_index) < 32'(lse_pkg::MAX_TERMS));
   assign ram_addr = ram_we ? lse_pkg::COEF_ADDR_W'(req_coef_index) : rd_addr;

   lse_ram #(
      .WIDTH(lse_pkg::COEF_W),
      .DEPTH(lse_pkg::MAX_TERMS)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(req_coef_value),
      .rd_data(rd_data)
   );

   lse_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_in (div_in),
      .div_out(div_out)
   );

   lse_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .inv_radius    (inv_radius_ff),
      .term_count    (term_count_ff),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .div_in        (div_in),
      .div_out       (div_out),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_series_sum(rsp_series_sum),
      .rsp_saturated (rsp_saturated)
   );

endmodule

[hw/rtl/lse_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module lse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lse_div.sv]
// Iterative signed divider for the recurrence, four quotient bits per cycle,
// truncating toward zero and clipping the quotient to [-1.0, 1.0] in Q2.30.
// Depends on lse_pkg.
module lse_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lse_pkg::div_in_type  div_in,
   output lse_pkg::div_out_type div_out
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [lse_pkg::ITER_W-1:0]        iter_ff, iter_in;
   logic [lse_pkg::TERM_CNT_W-1:0]    rem_ff, rem_in;
   logic [lse_pkg::TERM_CNT_W-1:0]    den_ff, den_in;
   logic [lse_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [lse_pkg::NUM_W-1:0]         mag;
   logic [lse_pkg::PW_W-1:0]          mag_clip;
   logic [lse_pkg::Q_W-1:0]           quot_pos;

   always_comb begin
      logic [lse_pkg::TERM_CNT_W:0]   r;
      logic [lse_pkg::TERM_CNT_W-1:0] rem_v;
      logic [lse_pkg::QUO_W-1:0]      quo_v;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      mag = div_in.num[lse_pkg::NUM_W-1] ? lse_pkg::NUM_W'(-div_in.num)
                                         : lse_pkg::NUM_W'(div_in.num);
      rem_v = rem_ff;
      quo_v = quo_ff;
      for (int i = 0; i < lse_pkg::DIV_BITS; i++) begin
         r = {rem_v, quo_v[lse_pkg::QUO_W-1]};
         quo_v = {quo_v[lse_pkg::QUO_W-2:0], 1'b0};
         if (r >= {1'b0, den_ff}) begin
            r = r - {1'b0, den_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = r[lse_pkg::TERM_CNT_W-1:0];
      end
      if (div_in.start) begin
         busy_in = 1'b1;
         neg_in  = div_in.num[lse_pkg::NUM_W-1];
         iter_in = lse_pkg::ITER_W'(lse_pkg::DIV_ITER);
         rem_in  = '0;
         den_in  = div_in.den;
         quo_in  = lse_pkg::QUO_W'(mag);
      end else if (busy_ff) begin
         rem_in  = rem_v;
         quo_in  = quo_v;
         iter_in = iter_ff - lse_pkg::ITER_W'(1);
         if (iter_ff == lse_pkg::ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign mag_clip = (quo_ff > lse_pkg::QUO_W'(lse_pkg::ONE_Q30))
                     ? lse_pkg::PW_W'(lse_pkg::ONE_Q30) : quo_ff[lse_pkg::PW_W-1:0];
   assign quot_pos = {1'b0, mag_clip};
   assign div_out.done = done_ff;
   assign div_out.quot = neg_ff ? $signed(-quot_pos) : $signed(quot_pos);

endmodule

[hw/rtl/lse_engine.sv]
// Sequencer of the series evaluation: one shared multiplier, the power,
// polynomial and accumulator registers, and the coefficient read stream.
// Depends on lse_pkg; drives the coefficient RAM and the divider.
module lse_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lse_pkg::eval_cmd_type                cmd,
   input  logic [31:0]                          inv_radius,
   input  logic [lse_pkg::TERM_COUNT_W-1:0]     term_count,
   output logic [lse_pkg::COEF_ADDR_W-1:0]      rd_addr,
   input  logic [lse_pkg::COEF_W-1:0]           rd_data,
   output lse_pkg::div_in_type                  div_in,
   input  lse_pkg::div_out_type                 div_out,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output logic signed [lse_pkg::SUM_W-1:0]     rsp_series_sum,
   output logic                                 rsp_saturated
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FR1    = 4'd1;
   localparam logic [3:0] ST_FR2    = 4'd2;
   localparam logic [3:0] ST_FETCH  = 4'd3;
   localparam logic [3:0] ST_CP     = 4'd4;
   localparam logic [3:0] ST_TERM   = 4'd5;
   localparam logic [3:0] ST_ETA    = 4'd6;
   localparam logic [3:0] ST_T1     = 4'd7;
   localparam logic [3:0] ST_T2     = 4'd8;
   localparam logic [3:0] ST_PW     = 4'd9;
   localparam logic [3:0] ST_DSTART = 4'd10;
   localparam logic [3:0] ST_DWAIT  = 4'd11;
   localparam logic [3:0] ST_DONE   = 4'd12;

   logic [3:0]                          state_ff, state_in;
   logic [lse_pkg::TERM_CNT_W-1:0]      k_ff, k_in;
   logic [lse_pkg::TERM_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [lse_pkg::TERM_CNT_W-1:0]      cnt_lim;
   logic [31:0]                         x_ff, x_in;
   logic signed [lse_pkg::Q_W-1:0]      eta_ff, eta_in;
   logic [lse_pkg::PW_W-1:0]            fr_ff, fr_in;
   logic [lse_pkg::PW_W-1:0]            pw_ff, pw_in;
   logic signed [lse_pkg::Q_W-1:0]      cur_ff, cur_in;
   logic signed [lse_pkg::Q_W-1:0]      prev_ff, prev_in;
   logic signed [lse_pkg::SUM_W-1:0]    acc_ff, acc_in;
   logic                                sat_ff, sat_in;
   logic signed [lse_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [lse_pkg::NUM_W-1:0]    p1_ff, p1_in;
   logic signed [lse_pkg::NUM_W-1:0]    num_ff, num_in;
   logic signed [lse_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic signed [lse_pkg::MUL_W-1:0]    prod_q30;
   logic [lse_pkg::FR_FULL_W-1:0]       fr_full;
   logic signed [lse_pkg::SUMX_W-1:0]   sum;

   assign prod_q30 = $signed(prod_ff[lse_pkg::Q_FRAC+lse_pkg::MUL_W-1:lse_pkg::Q_FRAC]);
   assign fr_full  = prod_ff[63:lse_pkg::FR_SHIFT];
   assign sum      = lse_pkg::SUMX_W'(acc_ff) + lse_pkg::SUMX_W'(prod_q30);
   assign cnt_lim  = (32'(term_count) > 32'(lse_pkg::MAX_TERMS))
                     ? lse_pkg::TERM_CNT_W'(lse_pkg::MAX_TERMS)
                     : lse_pkg::TERM_CNT_W'(term_count);
   assign prod_in  = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      eta_in   = eta_ff;
      fr_in    = fr_ff;
      pw_in    = pw_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      p1_in    = p1_ff;
      num_in   = num_ff;
      mul_a    = '0;
      mul_b    = '0;
      div_in.start = 1'b0;
      div_in.num   = num_ff;
      div_in.den   = k_ff + lse_pkg::TERM_CNT_W'(1);
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            state_in = ST_IDLE;
            if (cmd.valid) begin
               x_in     = cmd.radial_pos;
               eta_in   = cmd.eta;
               state_in = ST_FR1;
            end
         end
         ST_FR1: begin
            mul_a    = lse_pkg::MUL_W'(x_ff);
            mul_b    = lse_pkg::MUL_W'(inv_radius);
            state_in = ST_FR2;
         end
         ST_FR2: begin
            if (fr_full > lse_pkg::FR_FULL_W'(lse_pkg::ONE_Q30)) begin
               fr_in = lse_pkg::PW_W'(lse_pkg::ONE_Q30);
            end else begin
               fr_in = fr_full[lse_pkg::PW_W-1:0];
            end
            cnt_in   = cnt_lim;
            k_in     = '0;
            pw_in    = lse_pkg::PW_W'(lse_pkg::ONE_Q30);
            cur_in   = lse_pkg::Q_W'(lse_pkg::ONE_Q30);
            prev_in  = '0;
            acc_in   = '0;
            sat_in   = 1'b0;
            state_in = (cnt_lim == '0) ? ST_DONE : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_CP;
         end
         ST_CP: begin
            mul_a    = lse_pkg::MUL_W'($signed(rd_data));
            mul_b    = lse_pkg::MUL_W'(pw_ff);
            state_in = ST_TERM;
         end
         ST_TERM: begin
            mul_a    = prod_q30;
            mul_b    = lse_pkg::MUL_W'(cur_ff);
            state_in = ST_ETA;
         end
         ST_ETA: begin
            if (sum[lse_pkg::SUMX_W-1] != sum[lse_pkg::SUM_W-1]) begin
               acc_in = sum[lse_pkg::SUMX_W-1]
                        ? {1'b1, {(lse_pkg::SUM_W-1){1'b0}}}
                        : {1'b0, {(lse_pkg::SUM_W-1){1'b1}}};
               sat_in = 1'b1;
            end else begin
               acc_in = sum[lse_pkg::SUM_W-1:0];
            end
            mul_a    = lse_pkg::MUL_W'(eta_ff);
            mul_b    = lse_pkg::MUL_W'(cur_ff);
            state_in = (k_ff + lse_pkg::TERM_CNT_W'(1) == cnt_ff) ? ST_DONE : ST_T1;
         end
         ST_T1: begin
            mul_a    = prod_q30;
            mul_b    = lse_pkg::MUL_W'({k_ff, 1'b1});
            state_in = ST_T2;
         end
         ST_T2: begin
            p1_in    = prod_ff[lse_pkg::NUM_W-1:0];
            mul_a    = lse_pkg::MUL_W'(k_ff);
            mul_b    = lse_pkg::MUL_W'(prev_ff);
            state_in = ST_PW;
         end
         ST_PW: begin
            num_in   = p1_ff - $signed(prod_ff[lse_pkg::NUM_W-1:0]);
            mul_a    = lse_pkg::MUL_W'(pw_ff);
            mul_b    = lse_pkg::MUL_W'(fr_ff);
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            pw_in        = prod_ff[lse_pkg::Q_FRAC+lse_pkg::PW_W-1:lse_pkg::Q_FRAC];
            div_in.start = 1'b1;
            state_in     = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_out.done) begin
               cur_in   = div_out.quot;
               prev_in  = cur_ff;
               k_in     = k_ff + lse_pkg::TERM_CNT_W'(1);
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
      end
      x_ff    <= x_in;
      eta_ff  <= eta_in;
      fr_ff   <= fr_in;
      pw_ff   <= pw_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      acc_ff  <= acc_in;
      sat_ff  <= sat_in;
      prod_ff <= prod_in;
      p1_ff   <= p1_in;
      num_ff  <= num_in;
   end

   assign rd_addr        = k_ff[lse_pkg::COEF_ADDR_W-1:0];
   assign busy           = !(state_ff == ST_IDLE || state_ff == ST_DONE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_series_sum = acc_ff;
   assign rsp_saturated  = sat_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_out.done |-> state_ff == ST_DWAIT)
      else $error("Divider result arrived outside the wait state.");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> k_ff < cnt_ff)
      else $error("Term index ran past the term count.");

   a_cur_clipped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> (cur_ff <= lse_pkg::Q_W'(lse_pkg::ONE_Q30)
                                && cur_ff >= lse_pkg::Q_W'(-lse_pkg::ONE_Q30)))
      else $error("Polynomial value left the range of one.");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("One transaction produced two results.");

endmodule
